@@ rtl/core/csvfs_pkg.sv @@
// csvfs_pkg: shared types and character codes for the csv field splitter
// used by csvfs_in_stage, csvfs_parse and csv_field_splitter
// no dependencies
package csvfs_pkg;

    // default limit on fields per record
    localparam int MAX_FIELDS_DEF = 64;

    // output field widths
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    // character codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_csvfs_in;

    // result item
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_data;
        logic             field_end;
        logic             record_end;
        logic [IDX_W-1:0] field_index;
        logic [CNT_W-1:0] field_count;
        logic             field_overflow;
    } t_csvfs_out;

endpackage

@@ rtl/core/csvfs_in_stage.sv @@
// csvfs_in_stage: input register for the csv field splitter
// depends on csvfs_pkg
module csvfs_in_stage
    import csvfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_csvfs_in i_in_data,
    output logic      o_valid,
    output t_csvfs_in o_data,
    input  logic      i_take
);

    logic      r_valid;
    t_csvfs_in r_data;
    logic      w_load;

    // stall only while a held item cannot move on
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/csvfs_parse.sv @@
// csvfs_parse: per-byte parse state, next-state logic and result register
// depends on csvfs_pkg
module csvfs_parse
    import csvfs_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_csvfs_in  i_data,
    output logic       o_take,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_csvfs_out o_out_data
);

    localparam int FC_W = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
    localparam int FN_W = $clog2(MAX_FIELDS + 1);
    localparam int XW   = (FN_W > CNT_W) ? FN_W : CNT_W;
    localparam logic [FC_W-1:0] FC_LAST = FC_W'(MAX_FIELDS - 1);

    // parse phase codes
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_PLAIN = 2'd1;
    localparam logic [1:0] PH_QUOTE = 2'd2;
    localparam logic [1:0] PH_QSEEN = 2'd3;

    logic [1:0]      r_phase, n_phase;
    logic            r_acr, n_acr;
    logic            r_has, n_has;
    logic [FC_W-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;

    logic            r_out_valid;
    t_csvfs_out      r_out;

    logic            w_res;
    logic            w_fend;
    logic            w_rend;
    logic            w_data;
    logic [7:0]      w_byte;
    logic [FC_W-1:0] w_idx;
    logic [FN_W-1:0] w_count;
    logic            w_ovf;
    logic [XW-1:0]   w_idx_x;
    logic [XW-1:0]   w_count_x;
    logic            w_adv;
    logic [7:0]      w_c;

    assign w_c   = i_data.in_byte;
    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_take = w_adv;

    // next state and result for the held byte
    always_comb begin
        n_phase = r_phase;
        n_acr   = r_acr;
        n_has   = r_has;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        w_res   = 1'b0;
        w_fend  = 1'b0;
        w_rend  = 1'b0;
        w_data  = 1'b0;
        w_byte  = 8'h00;
        w_idx   = r_cnt;
        w_count = '0;
        w_ovf   = r_ovf;
        if (i_data.end_of_stream) begin
            // close a pending line and return to reset state
            if (r_has) begin
                w_res   = 1'b1;
                w_fend  = 1'b1;
                w_rend  = 1'b1;
                w_count = FN_W'(r_cnt) + FN_W'(1);
            end
            n_phase = PH_START;
            n_has   = 1'b0;
            n_cnt   = '0;
            n_ovf   = 1'b0;
            n_acr   = 1'b0;
        end else if (r_acr && w_c == CH_LF) begin
            // lf of a cr lf pair
            n_acr = 1'b0;
        end else if (w_c == CH_CR || w_c == CH_LF) begin
            // record end
            n_acr = (w_c == CH_CR);
            w_res  = 1'b1;
            w_rend = 1'b1;
            if (r_has) begin
                w_fend  = 1'b1;
                w_count = FN_W'(r_cnt) + FN_W'(1);
            end else begin
                w_idx = '0;
                w_ovf = 1'b0;
            end
            n_phase = PH_START;
            n_has   = 1'b0;
            n_cnt   = '0;
            n_ovf   = 1'b0;
        end else begin
            n_acr  = 1'b0;
            n_has  = 1'b1;
            w_byte = w_c;
            w_res  = 1'b1;
            w_data = 1'b1;
            case (r_phase)
                PH_START: begin
                    if (w_c == CH_QUOTE) begin
                        n_phase = PH_QUOTE;
                        w_res   = 1'b0;
                    end else if (w_c != CH_COMMA) begin
                        n_phase = PH_PLAIN;
                    end
                end
                PH_PLAIN: begin
                end
                PH_QUOTE: begin
                    if (w_c == CH_QUOTE) begin
                        n_phase = PH_QSEEN;
                        w_res   = 1'b0;
                    end
                end
                PH_QSEEN: begin
                    if (w_c == CH_QUOTE) begin
                        n_phase = PH_QUOTE;
                    end else if (w_c != CH_COMMA) begin
                        n_phase = PH_PLAIN;
                    end
                end
                default: begin
                end
            endcase
            // comma outside quotes closes the field
            if (w_c == CH_COMMA && r_phase != PH_QUOTE) begin
                w_data  = 1'b0;
                w_byte  = 8'h00;
                w_fend  = 1'b1;
                n_phase = PH_START;
                if (r_cnt == FC_LAST) begin
                    n_ovf = 1'b1;
                    w_ovf = 1'b1;
                end else begin
                    n_cnt = r_cnt + FC_W'(1);
                end
            end
        end
    end

    assign w_idx_x   = XW'(w_idx);
    assign w_count_x = XW'(w_count);

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acr   <= 1'b0;
            r_has   <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_valid && w_adv) begin
            r_phase <= n_phase;
            r_acr   <= n_acr;
            r_has   <= n_has;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= i_valid && w_res;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_byte       <= w_byte;
            r_out.is_data        <= w_data;
            r_out.field_end      <= w_fend;
            r_out.record_end     <= w_rend;
            r_out.field_index    <= w_idx_x[IDX_W-1:0];
            r_out.field_count    <= w_count_x[CNT_W-1:0];
            r_out.field_overflow <= w_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a data transfer never closes a field or record
    a_data_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_data |-> !r_out.field_end && !r_out.record_end)
        else $error("data result also marks an end");

    // every result is data, a field end or a record end
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.is_data |-> r_out.field_end || r_out.record_end)
        else $error("empty result");

    // empty line closes with zero index and count
    a_empty_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.record_end && !r_out.field_end
        |-> r_out.field_index == '0 && r_out.field_count == '0
            && !r_out.field_overflow)
        else $error("empty line result not cleared");

    // overflow only while the index sits at its limit
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_cnt == FC_LAST)
        else $error("overflow flag without saturated index");

    // a lf right after a cr ended record produces no result
    a_crlf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && w_adv && r_acr && !i_data.end_of_stream && w_c == CH_LF
        |=> !r_out_valid)
        else $error("lf of cr lf pair produced a result");

endmodule

@@ rtl/core/csv_field_splitter.sv @@
// csv_field_splitter: top level of the streaming csv field splitter
// depends on csvfs_pkg, csvfs_in_stage and csvfs_parse
//
// Takes one text byte per transfer and reports field data bytes, field ends
// and record ends, at most one result per byte. The block accepts one byte
// every cycle while the output is not stalled; a byte's result passes through
// the input register and then the result register, with the one-byte parse
// decision between them. A downstream stall holds the result register and
// then the input register; the input side stalls only when both are full.
// Quoted fields, doubled quotes, CR, LF and CR LF record ends and end of
// stream are handled as the usual CSV rules; the field index saturates at
// MAX_FIELDS-1 and raises field_overflow.
module csv_field_splitter
    import csvfs_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_csvfs_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_csvfs_out o_out_data
);

    logic      w_valid;
    t_csvfs_in w_data;
    logic      w_take;

    // input register
    csvfs_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_valid    (w_valid),
        .o_data     (w_data),
        .i_take     (w_take)
    );

    // parse step and result register
    csvfs_parse #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_data      (w_data),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/tb_csv_field_splitter.sv @@
`timescale 1ns / 100ps
// tb_csv_field_splitter: self-checking testbench for the csv field splitter
// depends on csvfs_pkg and the csv_field_splitter rtl; predicts every result in place
module tb_csv_field_splitter;
    import csvfs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 160;

    typedef enum logic [1:0] {
        PH_START,
        PH_PLAIN,
        PH_QUOTED,
        PH_QUOTE_SEEN
    } t_parse_phase;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_csvfs_in  i_in_data   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_csvfs_out o_out_data;

    // splitter state as the predictor tracks it
    t_parse_phase     parse_ph;
    bit               cr_pending;
    bit               line_busy;
    logic [CNT_W-1:0] field_no;
    bit               overflowed;

    t_csvfs_out expected_results[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int sent_count    = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    csv_field_splitter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("csv_field_splitter test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_line_state();
        parse_ph   = PH_START;
        line_busy  = 1'b0;
        field_no   = '0;
        overflowed = 1'b0;
    endfunction

    function automatic t_csvfs_out data_result(input logic [7:0] c);
        t_csvfs_out r;
        r                = '0;
        r.out_byte       = c;
        r.is_data        = 1'b1;
        r.field_index    = field_no[IDX_W-1:0];
        r.field_overflow = overflowed;
        return r;
    endfunction

    // close the current field; index saturates at the last slot
    function automatic t_csvfs_out field_close_result();
        t_csvfs_out r;
        r             = '0;
        r.field_end   = 1'b1;
        r.field_index = field_no[IDX_W-1:0];
        if (field_no + 1 >= MAX_FIELDS_DEF)
            overflowed = 1'b1;
        else
            field_no = field_no + 1'b1;
        parse_ph         = PH_START;
        r.field_overflow = overflowed;
        return r;
    endfunction

    // close the line; an empty line reports zero fields
    function automatic t_csvfs_out record_close_result();
        t_csvfs_out r;
        r            = '0;
        r.record_end = 1'b1;
        if (line_busy) begin
            r.field_end      = 1'b1;
            r.field_index    = field_no[IDX_W-1:0];
            r.field_count    = field_no + 1'b1;
            r.field_overflow = overflowed;
        end
        clear_line_state();
        return r;
    endfunction

    task automatic predict_transfer(input logic [7:0] c, input logic eos);
        t_csvfs_out r;
        bit         emit;
        r    = '0;
        emit = 1'b0;
        if (eos) begin
            if (line_busy) begin
                r    = record_close_result();
                emit = 1'b1;
            end
            clear_line_state();
            cr_pending = 1'b0;
        end else if (cr_pending && c == CH_LF) begin
            // lf of a cr lf pair is swallowed
            cr_pending = 1'b0;
        end else begin
            cr_pending = 1'b0;
            if (c == CH_CR || c == CH_LF) begin
                cr_pending = (c == CH_CR);
                r          = record_close_result();
                emit       = 1'b1;
            end else begin
                line_busy = 1'b1;
                emit      = 1'b1;
                case (parse_ph)
                    PH_START: begin
                        if (c == CH_QUOTE) begin
                            parse_ph = PH_QUOTED;
                            emit     = 1'b0;
                        end else if (c == CH_COMMA) begin
                            r = field_close_result();
                        end else begin
                            parse_ph = PH_PLAIN;
                            r        = data_result(c);
                        end
                    end
                    PH_PLAIN: begin
                        if (c == CH_COMMA)
                            r = field_close_result();
                        else
                            r = data_result(c);
                    end
                    PH_QUOTED: begin
                        if (c == CH_QUOTE) begin
                            parse_ph = PH_QUOTE_SEEN;
                            emit     = 1'b0;
                        end else begin
                            r = data_result(c);
                        end
                    end
                    default: begin
                        // quote seen inside quotes: doubled quote, comma or trailing text
                        if (c == CH_QUOTE) begin
                            parse_ph = PH_QUOTED;
                            r        = data_result(c);
                        end else if (c == CH_COMMA) begin
                            r = field_close_result();
                        end else begin
                            parse_ph = PH_PLAIN;
                            r        = data_result(c);
                        end
                    end
                endcase
            end
        end
        if (emit)
            expected_results.push_back(r);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result(input t_csvfs_out got);
        t_csvfs_out want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: out_byte %0h", got.out_byte);
            err_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("is_data", 8'(want.is_data), 8'(got.is_data));
        check_field("field_end", 8'(want.field_end), 8'(got.field_end));
        check_field("record_end", 8'(want.record_end), 8'(got.record_end));
        check_field("field_index", 8'(want.field_index), 8'(got.field_index));
        check_field("field_count", 8'(want.field_count), 8'(got.field_count));
        check_field("field_overflow", 8'(want.field_overflow), 8'(got.field_overflow));
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result(o_out_data);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // offer one byte, with random idle cycles first, until the transfer happens
    task automatic send_byte(input logic [7:0] c, input logic eos);
        t_csvfs_in item;
        item.in_byte       = c;
        item.end_of_stream = eos;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_transfer(c, eos);
        sent_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // text byte that is never cr, lf or quote; comma only when allowed
    function automatic logic [7:0] rand_text_byte(input bit allow_comma);
        logic [7:0] c;
        if ($urandom_range(1))
            return 8'h61 + 8'($urandom_range(25));  // lower-case letter
        do
            c = 8'($urandom);
        while (c == CH_CR || c == CH_LF || c == CH_QUOTE || (!allow_comma && c == CH_COMMA));
        return c;
    endfunction

    task automatic send_line_end();
        case ($urandom_range(2))
            0: send_byte(CH_CR, 1'b0);
            1: send_byte(CH_LF, 1'b0);
            default: begin
                send_byte(CH_CR, 1'b0);
                send_byte(CH_LF, 1'b0);
            end
        endcase
    endtask

    task automatic send_field(input bit quoted);
        int n;
        n = $urandom_range(4);
        if (!quoted) begin
            repeat (n) send_byte(rand_text_byte(1'b0), 1'b0);
        end else begin
            send_byte(CH_QUOTE, 1'b0);
            repeat (n) begin
                case ($urandom_range(3))
                    0: send_byte(CH_COMMA, 1'b0);
                    1: begin
                        send_byte(CH_QUOTE, 1'b0);
                        send_byte(CH_QUOTE, 1'b0);
                    end
                    default: send_byte(rand_text_byte(1'b1), 1'b0);
                endcase
            end
            // mostly closed, sometimes with text after the closing quote
            if ($urandom_range(9) != 0) begin
                send_byte(CH_QUOTE, 1'b0);
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 2)) send_byte(rand_text_byte(1'b0), 1'b0);
            end
        end
    endtask

    // mostly well-formed records, some noise, empty lines and stream ends
    task automatic send_random_line();
        int kind;
        int n_fields;
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
        end else if (kind < 10) begin
            send_line_end();
        end else if (kind < 13) begin
            send_byte(8'($urandom), 1'b1);
        end else begin
            n_fields = ($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
            for (int i = 0; i < n_fields; i++) begin
                if (i > 0)
                    send_byte(CH_COMMA, 1'b0);
                send_field($urandom_range(2) == 0);
            end
            if ($urandom_range(19) == 0)
                send_byte(8'($urandom), 1'b1);
            else
                send_line_end();
        end
    endtask

    // ---------------------------------------------------------------- tests

    // extreme bytes, empty field from a trailing comma, cr lf end, then an empty line
    task automatic test_plain_fields();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_LF, 1'b0);
        wait_drained();
    endtask

    // comma inside quotes, doubled quote, text after the closing quote
    task automatic test_quoted_field();
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(CH_LF, 1'b0);
        wait_drained();
    endtask

    // quote left open at the line end, then cr cr gives an empty line
    task automatic test_unclosed_quote();
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_CR, 1'b0);
        wait_drained();
    endtask

    // stream end on an empty line and on a pending line
    task automatic test_end_of_stream();
        send_byte(8'h00, 1'b1);
        send_byte(8'h6B, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // more commas than field slots
    task automatic test_field_overflow();
        send_byte(8'h61, 1'b0);
        repeat (MAX_FIELDS_DEF + 1) send_byte(CH_COMMA, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(CH_LF, 1'b0);
        wait_drained();
    endtask

    // long downstream hold while bytes keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        repeat (8) send_random_line();
        wait_drained();
    endtask

    task automatic test_random(input int idle_pct, input int hold_pct, input int n_items);
        int target;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        target        = sent_count + n_items;
        while (sent_count < target)
            send_random_line();
        wait_drained();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_line_state();
        cr_pending = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_fields();
        test_quoted_field();
        test_unclosed_quote();
        test_end_of_stream();
        test_field_overflow();
        test_backpressure();
        test_random(0, 0, PHASE_ITEMS);
        test_random(77, 0, PHASE_ITEMS);
        test_random(0, 77, PHASE_ITEMS);
        test_random(12, 12, PHASE_ITEMS);

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_drained();
        if (err_count == 0)
            $display("csv_field_splitter test passed");
        else
            $display("csv_field_splitter test failed");
        $finish;
    end

endmodule
